FILE: rtl/phsc_pkg.sv
package phsc_pkg;

  localparam int RAW_T_W    = 20;
  localparam int RAW_P_W    = 20;
  localparam int RAW_H_W    = 16;
  localparam int HUM_W      = 17;
  localparam int DIV_W      = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 120;

  // register indexes, paddr[5:3]
  localparam logic [2:0] REG_TEMP      = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW = 3'd1;
  localparam logic [2:0] REG_PRESS_HI  = 3'd2;
  localparam logic [2:0] REG_PRESS_HUM = 3'd3;
  localparam logic [2:0] REG_HUM_REST  = 3'd4;

  // 100.00 %RH in Q22.10, shifted left by 12
  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } coef_t;

  // results that ride alongside the pressure divider
  typedef struct packed {
    logic [31:0]      tc;
    logic [31:0]      tf;
    logic [HUM_W-1:0] hum;
    logic             dz;
  } side_t;

endpackage

FILE: rtl/phsc_regs.sv
module phsc_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [phsc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [phsc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [phsc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output phsc_pkg::coef_t                     coef
);

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [47:0] press_last_hum_first;
  logic [39:0] hum_coeffs_rest;
  logic [2:0]  idx;
  logic        wr;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs          <= '0;
      press_coeffs_low     <= '0;
      press_coeffs_high    <= '0;
      press_last_hum_first <= '0;
      hum_coeffs_rest      <= '0;
    end else if (wr) begin
      case (idx)
        phsc_pkg::REG_TEMP:      temp_coeffs          <= pwdata[47:0];
        phsc_pkg::REG_PRESS_LOW: press_coeffs_low     <= pwdata;
        phsc_pkg::REG_PRESS_HI:  press_coeffs_high    <= pwdata;
        phsc_pkg::REG_PRESS_HUM: press_last_hum_first <= pwdata[47:0];
        phsc_pkg::REG_HUM_REST:  hum_coeffs_rest      <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      phsc_pkg::REG_TEMP:      prdata = {16'd0, temp_coeffs};
      phsc_pkg::REG_PRESS_LOW: prdata = press_coeffs_low;
      phsc_pkg::REG_PRESS_HI:  prdata = press_coeffs_high;
      phsc_pkg::REG_PRESS_HUM: prdata = {16'd0, press_last_hum_first};
      phsc_pkg::REG_HUM_REST:  prdata = {24'd0, hum_coeffs_rest};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    coef.t1 = temp_coeffs[15:0];
    coef.t2 = temp_coeffs[31:16];
    coef.t3 = temp_coeffs[47:32];
    coef.p1 = press_coeffs_low[15:0];
    coef.p2 = press_coeffs_low[31:16];
    coef.p3 = press_coeffs_low[47:32];
    coef.p4 = press_coeffs_low[63:48];
    coef.p5 = press_coeffs_high[15:0];
    coef.p6 = press_coeffs_high[31:16];
    coef.p7 = press_coeffs_high[47:32];
    coef.p8 = press_coeffs_high[63:48];
    coef.p9 = press_last_hum_first[15:0];
    coef.h1 = press_last_hum_first[23:16];
    coef.h2 = press_last_hum_first[39:24];
    coef.h3 = press_last_hum_first[47:40];
    coef.h4 = hum_coeffs_rest[15:0];
    coef.h5 = hum_coeffs_rest[31:16];
    coef.h6 = hum_coeffs_rest[39:32];
  end

endmodule

FILE: rtl/phsc_front.sv
module phsc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic [phsc_pkg::RAW_T_W-1:0]     raw_temperature,
  input  logic [phsc_pkg::RAW_P_W-1:0]     raw_pressure,
  input  logic [phsc_pkg::RAW_H_W-1:0]     raw_humidity,
  input  phsc_pkg::coef_t                  coef,
  output logic                             out_valid,
  output logic [phsc_pkg::DIV_W-1:0]       num,
  output logic [phsc_pkg::DIV_W-1:0]       den,
  output phsc_pkg::side_t                  side
);

  logic [8:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  assign out_valid = vld[8];

  // stage 1: temperature products
  logic [31:0] td;
  logic [31:0] s1_ta;
  logic [31:0] s1_dd;
  logic [phsc_pkg::RAW_P_W-1:0] s1_rp;
  logic [phsc_pkg::RAW_H_W-1:0] s1_rh;

  assign td = 32'(raw_temperature >> 4) - 32'(coef.t1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ta <= (32'(raw_temperature >> 3) - {15'd0, coef.t1, 1'b0}) * 32'($signed(coef.t2));
      s1_dd <= td * td;
      s1_rp <= raw_pressure;
      s1_rh <= raw_humidity;
    end
  end

  // stage 2
  logic signed [31:0] dd12;
  logic signed [31:0] s2_v1;
  logic signed [31:0] s2_m;
  logic [phsc_pkg::RAW_P_W-1:0] s2_rp;
  logic [phsc_pkg::RAW_H_W-1:0] s2_rh;

  assign dd12 = $signed(s1_dd) >>> 12;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_v1 <= $signed(s1_ta) >>> 11;
      s2_m  <= dd12 * 32'($signed(coef.t3));
      s2_rp <= s1_rp;
      s2_rh <= s1_rh;
    end
  end

  // stage 3: fine temperature
  logic signed [31:0] s3_tf;
  logic [phsc_pkg::RAW_P_W-1:0] s3_rp;
  logic [phsc_pkg::RAW_H_W-1:0] s3_rh;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tf <= s2_v1 + (s2_m >>> 14);
      s3_rp <= s2_rp;
      s3_rh <= s2_rh;
    end
  end

  // stage 4: centi-degrees, first pressure and humidity products
  logic signed [32:0] x1;
  logic signed [65:0] xsq_full;
  logic signed [48:0] xp5_full;
  logic signed [48:0] xp2_full;
  logic signed [31:0] hv;
  logic signed [31:0] tc5;
  logic signed [31:0] s4_tc;
  logic signed [31:0] s4_tf;
  logic signed [63:0] s4_xsq;
  logic signed [63:0] s4_xp5;
  logic signed [63:0] s4_xp2;
  logic signed [31:0] s4_hv5;
  logic signed [31:0] s4_hv6;
  logic signed [31:0] s4_hv3;
  logic [phsc_pkg::RAW_P_W-1:0] s4_rp;
  logic [phsc_pkg::RAW_H_W-1:0] s4_rh;

  assign x1       = 33'(s3_tf) - 33'sd128000;
  assign xsq_full = x1 * x1;
  assign xp5_full = x1 * $signed(coef.p5);
  assign xp2_full = x1 * $signed(coef.p2);
  assign hv       = s3_tf - 32'sd76800;
  assign tc5      = s3_tf * 32'sd5 + 32'sd128;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_tc  <= tc5 >>> 8;
      s4_tf  <= s3_tf;
      s4_xsq <= $signed(xsq_full[63:0]);
      s4_xp5 <= 64'(xp5_full);
      s4_xp2 <= 64'(xp2_full);
      s4_hv5 <= hv * 32'($signed(coef.h5));
      s4_hv6 <= hv * 32'($signed(coef.h6));
      s4_hv3 <= hv * $signed({24'd0, coef.h3});
      s4_rp  <= s3_rp;
      s4_rh  <= s3_rh;
    end
  end

  // stage 5
  logic signed [31:0] hxs;
  logic signed [63:0] s5_xsq6;
  logic signed [63:0] s5_xsq3;
  logic signed [63:0] s5_xp5;
  logic signed [63:0] s5_xp2;
  logic signed [31:0] s5_hx;
  logic signed [31:0] s5_hyp;
  logic signed [31:0] s5_tc;
  logic signed [31:0] s5_tf;
  logic [phsc_pkg::RAW_P_W-1:0] s5_rp;

  assign hxs = $signed({2'b00, s4_rh, 14'd0}) - (32'($signed(coef.h4)) <<< 20)
               - s4_hv5 + 32'sd16384;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_xsq6 <= s4_xsq * 64'($signed(coef.p6));
      s5_xsq3 <= s4_xsq * 64'($signed(coef.p3));
      s5_xp5  <= s4_xp5;
      s5_xp2  <= s4_xp2;
      s5_hx   <= hxs >>> 15;
      s5_hyp  <= (s4_hv6 >>> 10) * ((s4_hv3 >>> 11) + 32'sd32768);
      s5_tc   <= s4_tc;
      s5_tf   <= s4_tf;
      s5_rp   <= s4_rp;
    end
  end

  // stage 6
  logic signed [31:0] hy;
  logic signed [63:0] s6_x2;
  logic signed [63:0] s6_x1c;
  logic signed [31:0] s6_hzp;
  logic signed [31:0] s6_hx;
  logic signed [31:0] s6_tc;
  logic signed [31:0] s6_tf;
  logic [phsc_pkg::RAW_P_W-1:0] s6_rp;

  assign hy = (s5_hyp >>> 10) + 32'sd2097152;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_x2  <= s5_xsq6 + (s5_xp5 <<< 17) + (64'($signed(coef.p4)) <<< 35);
      s6_x1c <= 64'sh0000_8000_0000_0000 + (s5_xsq3 >>> 8) + (s5_xp2 <<< 12);
      s6_hzp <= hy * 32'($signed(coef.h2)) + 32'sd8192;
      s6_hx  <= s5_hx;
      s6_tc  <= s5_tc;
      s6_tf  <= s5_tf;
      s6_rp  <= s5_rp;
    end
  end

  // stage 7: divisor and raw numerator
  logic signed [63:0] x1p;
  logic [20:0]        pbase;
  logic signed [63:0] s7_den;
  logic [63:0]        s7_num0;
  logic signed [31:0] s7_hv;
  logic signed [31:0] s7_tc;
  logic signed [31:0] s7_tf;

  assign x1p   = s6_x1c * $signed({48'd0, coef.p1});
  assign pbase = 21'd1048576 - {1'b0, s6_rp};

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_den  <= x1p >>> 33;
      s7_num0 <= {12'd0, pbase, 31'd0} - s6_x2;
      s7_hv   <= s6_hx * (s6_hzp >>> 14);
      s7_tc   <= s6_tc;
      s7_tf   <= s6_tf;
    end
  end

  // stage 8
  logic signed [31:0] sq;
  logic [63:0]        s8_num;
  logic [63:0]        s8_den;
  logic               s8_dz;
  logic signed [31:0] s8_hv;
  logic signed [31:0] s8_sqsq;
  logic signed [31:0] s8_tc;
  logic signed [31:0] s8_tf;

  assign sq = s7_hv >>> 15;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_num  <= s7_num0 * 64'd3125;
      s8_den  <= s7_den;
      s8_dz   <= (s7_den == 64'sd0);
      s8_hv   <= s7_hv;
      s8_sqsq <= sq * sq;
      s8_tc   <= s7_tc;
      s8_tf   <= s7_tf;
    end
  end

  // stage 9: finish humidity, clamp
  logic signed [31:0] ht;
  logic signed [31:0] hf;
  logic signed [31:0] hcl;
  logic [63:0]        s9_num;
  logic [63:0]        s9_den;
  logic               s9_dz;
  logic [phsc_pkg::HUM_W-1:0] s9_hum;
  logic signed [31:0] s9_tc;
  logic signed [31:0] s9_tf;

  assign ht = (s8_sqsq >>> 7) * $signed({24'd0, coef.h1});
  assign hf = s8_hv - (ht >>> 4);

  always_comb begin
    if (hf[31]) begin
      hcl = '0;
    end else if (hf > phsc_pkg::HUM_MAX) begin
      hcl = phsc_pkg::HUM_MAX;
    end else begin
      hcl = hf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_num <= s8_num;
      s9_den <= s8_den;
      s9_dz  <= s8_dz;
      s9_hum <= hcl[28:12];
      s9_tc  <= s8_tc;
      s9_tf  <= s8_tf;
    end
  end

  assign num      = s9_num;
  assign den      = s9_den;
  assign side.tc  = s9_tc;
  assign side.tf  = s9_tf;
  assign side.hum = s9_hum;
  assign side.dz  = s9_dz;

endmodule

FILE: rtl/phsc_div.sv
module phsc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [phsc_pkg::DIV_W-1:0]   num,
  input  logic [phsc_pkg::DIV_W-1:0]   den,
  input  phsc_pkg::side_t              in_side,
  output logic                         out_valid,
  output logic [phsc_pkg::DIV_W-1:0]   quo,
  output phsc_pkg::side_t              out_side
);

  localparam int W = phsc_pkg::DIV_W;

  logic [W+1:0]    vld;
  logic [W-1:0]    rem [0:W-1];
  logic [W-1:0]    dsr [0:W-1];
  logic [W-1:0]    dq  [0:W];
  logic            ngt [0:W];
  phsc_pkg::side_t sd  [0:W];
  logic [W-1:0]    shl [0:W-1];
  logic            ge  [0:W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[W:0], in_valid};
    end
  end

  assign out_valid = vld[W+1];

  // one restoring step per stage, quotient bits shift in behind the dividend
  always_comb begin
    for (int k = 0; k < W; k++) begin
      shl[k] = {rem[k][W-2:0], dq[k][W-1]};
      ge[k]  = shl[k] >= dsr[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // take magnitudes, remember the quotient sign
      dq[0]  <= num[W-1] ? -num : num;
      dsr[0] <= den[W-1] ? -den : den;
      ngt[0] <= num[W-1] ^ den[W-1];
      rem[0] <= '0;
      sd[0]  <= in_side;
      for (int k = 0; k < W; k++) begin
        dq[k+1]  <= {dq[k][W-2:0], ge[k]};
        ngt[k+1] <= ngt[k];
        sd[k+1]  <= sd[k];
      end
      for (int k = 0; k < W - 1; k++) begin
        rem[k+1] <= ge[k] ? shl[k] - dsr[k] : shl[k];
        dsr[k+1] <= dsr[k];
      end
      quo      <= ngt[W] ? -dq[W] : dq[W];
      out_side <= sd[W];
    end
  end

endmodule

FILE: rtl/phsc_back.sv
module phsc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [phsc_pkg::DIV_W-1:0]   quo,
  input  phsc_pkg::side_t              in_side,
  input  phsc_pkg::coef_t              coef,
  output logic                         out_valid,
  output logic [31:0]                  pressure,
  output phsc_pkg::side_t              out_side
);

  logic [3:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  assign out_valid = vld[3];

  // stage 1
  logic signed [63:0] ps;
  logic signed [63:0] s1_q;
  logic signed [63:0] s1_ps;
  logic signed [63:0] s1_m;
  logic signed [63:0] s1_y2m;
  phsc_pkg::side_t    s1_side;

  assign ps = $signed(quo) >>> 13;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q    <= $signed(quo);
      s1_ps   <= ps;
      s1_m    <= 64'($signed(coef.p9)) * ps;
      s1_y2m  <= 64'($signed(coef.p8)) * $signed(quo);
      s1_side <= in_side;
    end
  end

  // stage 2: 32-bit partial products for the low 64 bits of m * ps
  logic [63:0]        s2_pp0;
  logic [31:0]        s2_pp1;
  logic [31:0]        s2_pp2;
  logic signed [63:0] s2_q;
  logic signed [63:0] s2_y2m;
  phsc_pkg::side_t    s2_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pp0  <= {32'd0, s1_m[31:0]} * {32'd0, s1_ps[31:0]};
      s2_pp1  <= s1_m[63:32] * s1_ps[31:0];
      s2_pp2  <= s1_m[31:0] * s1_ps[63:32];
      s2_q    <= s1_q;
      s2_y2m  <= s1_y2m;
      s2_side <= s1_side;
    end
  end

  // stage 3
  logic [63:0]        y1p;
  logic signed [63:0] y1;
  logic signed [63:0] s3_sum;
  phsc_pkg::side_t    s3_side;

  assign y1p = s2_pp0 + {s2_pp1 + s2_pp2, 32'd0};
  assign y1  = $signed(y1p) >>> 25;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sum  <= s2_q + y1 + (s2_y2m >>> 19);
      s3_side <= s2_side;
    end
  end

  // stage 4: output register
  logic signed [63:0] pv;

  assign pv = (s3_sum >>> 8) + (64'($signed(coef.p7)) <<< 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      pressure <= s3_side.dz ? 32'd0 : pv[31:0];
      out_side <= s3_side;
    end
  end

endmodule

FILE: rtl/pressure_humidity_sensor_compensation.sv
// Compensates one set of raw temperature, pressure and humidity readings per
// transfer into centi-degrees, fine temperature, Q24.8 pressure and clamped
// Q22.10 humidity. The datapath is a fully pipelined chain: 9 stages for the
// temperature, humidity and pressure polynomial, 66 stages for the 64-bit
// signed divider (one quotient bit per restoring stage between its input and
// output registers) and 4 stages after the divide. One reading set is taken
// every cycle while m_tready is high. A full output stalls the whole chain.
// Coefficients are read straight from the registers: write them only while
// no transfer is in flight.
module pressure_humidity_sensor_compensation (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  input  logic [phsc_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // temperature_centi[31:0], fine_temperature[63:32], pressure_q24_8[95:64],
  // humidity_q22_10[112:96], zero fill above
  output logic [phsc_pkg::OUT_DATA_W-1:0]      m_tdata,
  // pressure_div_zero[0]
  output logic                                 m_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [phsc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [phsc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [phsc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  phsc_pkg::coef_t coef;
  phsc_pkg::side_t f_side;
  phsc_pkg::side_t d_side;
  phsc_pkg::side_t b_side;
  logic            adv;
  logic            f_valid;
  logic            d_valid;
  logic [63:0]     f_num;
  logic [63:0]     f_den;
  logic [63:0]     d_quo;
  logic [31:0]     b_pres;

  // advance every stage unless the result at the output is held
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  phsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  phsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (s_tvalid),
    .raw_temperature (s_tdata[19:0]),
    .raw_pressure    (s_tdata[39:20]),
    .raw_humidity    (s_tdata[55:40]),
    .coef            (coef),
    .out_valid       (f_valid),
    .num             (f_num),
    .den             (f_den),
    .side            (f_side)
  );

  phsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .out_side  (d_side)
  );

  phsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .quo       (d_quo),
    .in_side   (d_side),
    .coef      (coef),
    .out_valid (m_tvalid),
    .pressure  (b_pres),
    .out_side  (b_side)
  );

  assign m_tdata = {7'd0, b_side.hum, b_pres, b_side.tf, b_side.tc};
  assign m_tuser = b_side.dz;

  a_dz_forces_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[95:64] == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

  a_hum_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[112:96] <= 17'd102400)
    else $error("humidity above clamp limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
